// File: hw/rtl/lpmr_pkg.sv
// ----------------------------------------------------------------------------
// lpmr_pkg
// Shared types and constants of the length-prefixed message ring.
// ----------------------------------------------------------------------------
package lpmr_pkg;

  localparam int unsigned HDR_BYTES = 4;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_CAP_LOW = 3'd3,
    ST_TOO_BIG = 3'd4
  } status_t;

  typedef struct packed {
    logic        op;
    logic [7:0]  push_byte;
    logic [11:0] push_length;
    logic [15:0] read_capacity;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  pop_byte;
    logic [15:0] reported_length;
    logic        last;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PU_HDR,
    S_PU_DATA,
    S_PU_DROP,
    S_PO_RD0,
    S_PO_RD1,
    S_PO_RD2,
    S_PO_RD3,
    S_PO_HWAIT,
    S_PO_DECIDE,
    S_PO_BYTE,
    S_PO_BWAIT,
    S_EMIT
  } eng_state_t;

endpackage

// File: hw/rtl/lpmr_ram.sv
// ----------------------------------------------------------------------------
// lpmr_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module lpmr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: hw/rtl/lpmr_front.sv
// ----------------------------------------------------------------------------
// lpmr_front
// Input stage: registers accepted items into a two-entry queue.
// ----------------------------------------------------------------------------
module lpmr_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  lpmr_pkg::cmd_t  in_cmd,
  output logic            q_valid,
  input  logic            q_ready,
  output lpmr_pkg::cmd_t  q_cmd
);
  import lpmr_pkg::*;

  cmd_t       buf_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, rd_nxt;
  logic       wr_r, wr_nxt;
  logic       push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = buf_r[rd_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
    rd_nxt  = rd_r ^ pop;
    wr_nxt  = wr_r ^ push;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_r] <= in_cmd;
    end
  end

endmodule

// File: hw/rtl/lpmr_engine.sv
// ----------------------------------------------------------------------------
// lpmr_engine
// Back end: executes push and pop beats against the byte ring.
// ----------------------------------------------------------------------------
module lpmr_engine #(
  parameter int unsigned BUFFER_BYTES = 4096
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_ready,
  input  lpmr_pkg::cmd_t  q_cmd,
  output logic            out_valid,
  input  logic            out_ready,
  output lpmr_pkg::rsp_t  out_rsp
);
  import lpmr_pkg::*;

  localparam int unsigned AW = $clog2(BUFFER_BYTES);
  localparam int unsigned FW = AW + 1;
  localparam logic [FW-1:0] DEPTH_F = FW'(BUFFER_BYTES);
  localparam logic [AW-1:0] LAST_IX = AW'(BUFFER_BYTES - 1);

  eng_state_t state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [AW-1:0] wcur_r, wcur_nxt, rcur_r, rcur_nxt;
  logic [AW-1:0] hp_r, hp_nxt;
  logic [11:0]   prem_r, prem_nxt, orem_r, orem_nxt;
  logic          drop_r, drop_nxt, act_r, act_nxt;
  logic [1:0]    hk_r, hk_nxt;
  logic [11:0]   len_r, len_nxt;
  logic [31:0]   hdr_r, hdr_nxt;
  cmd_t          cmd_r, cmd_nxt;
  rsp_t          rsp_r, rsp_nxt;
  logic          ov_r, ov_nxt;
  logic          we;
  logic [AW-1:0] addr;
  logic [7:0]    wdata, rdata;
  logic [FW-1:0] free_bytes;
  logic [32:0]   need;
  logic [32:0]   hdr_p4;

  function automatic logic [AW-1:0] nx(input logic [AW-1:0] i);
    return (i == LAST_IX) ? '0 : i + 1'b1;
  endfunction

  lpmr_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  assign q_ready    = (state_r == S_IDLE) && !ov_r;
  assign out_valid  = ov_r;
  assign out_rsp    = rsp_r;
  assign free_bytes = (head_r > tail_r) ? {1'b0, head_r - tail_r}
                                        : {1'b0, head_r} + DEPTH_F - {1'b0, tail_r};
  assign need       = {21'd0, cmd_r.push_length} + 33'd4;
  assign hdr_p4     = {1'b0, hdr_r} + 33'd4;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (q_valid && !ov_r) begin
          if (!q_cmd.op) begin
            state_nxt = S_PU_HDR;
          end else begin
            state_nxt = S_PO_RD0;
          end
        end
      end
      S_PU_HDR: begin
        if (prem_r != 12'd0) begin
          state_nxt = drop_r ? S_PU_DROP : S_PU_DATA;
        end else if (33'(free_bytes) <= need) begin
          state_nxt = S_PU_DROP;
        end else if (hk_r == 2'd3) begin
          state_nxt = S_PU_DATA;
        end
      end
      S_PU_DATA:  state_nxt = S_EMIT;
      S_PU_DROP:  state_nxt = S_EMIT;
      S_PO_RD0:   state_nxt = S_PO_RD1;
      S_PO_RD1:   state_nxt = S_PO_RD2;
      S_PO_RD2:   state_nxt = S_PO_RD3;
      S_PO_RD3:   state_nxt = S_PO_HWAIT;
      S_PO_HWAIT: state_nxt = S_PO_DECIDE;
      S_PO_DECIDE: begin
        if (act_r) begin
          state_nxt = S_PO_BYTE;
        end else if (head_r == tail_r || cmd_r.read_capacity < 16'd4
                     || hdr_p4 > {17'd0, cmd_r.read_capacity}
                     || hdr_r == 32'd0) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_PO_BYTE;
        end
      end
      S_PO_BYTE:  state_nxt = S_PO_BWAIT;
      S_PO_BWAIT: state_nxt = S_EMIT;
      S_EMIT:     state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    head_nxt = head_r; tail_nxt = tail_r; wcur_nxt = wcur_r; rcur_nxt = rcur_r;
    hp_nxt = hp_r; prem_nxt = prem_r; orem_nxt = orem_r; drop_nxt = drop_r;
    act_nxt = act_r; hk_nxt = hk_r; len_nxt = len_r; hdr_nxt = hdr_r;
    cmd_nxt = cmd_r; rsp_nxt = rsp_r; ov_nxt = ov_r;
    we = 1'b0; addr = hp_r; wdata = 8'd0;
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        cmd_nxt = q_cmd;
        hk_nxt  = 2'd0;
        hp_nxt  = head_r;
        if (!ov_r) begin
          rsp_nxt = '0;
        end
      end
      S_PU_HDR: begin
        if (prem_r == 12'd0) begin
          if (33'(free_bytes) <= need) begin
            drop_nxt = 1'b1;
            prem_nxt = (cmd_r.push_length == 12'd0) ? 12'd1 : cmd_r.push_length;
          end else begin
            we    = 1'b1;
            addr  = (hk_r == 2'd0) ? tail_r : wcur_r;
            wdata = (hk_r == 2'd1) ? {4'd0, cmd_r.push_length[11:8]}
                  : (hk_r == 2'd0) ? cmd_r.push_length[7:0] : 8'd0;
            wcur_nxt = nx(addr);
            hk_nxt   = hk_r + 2'd1;
            if (hk_r == 2'd3) begin
              drop_nxt = 1'b0;
              prem_nxt = (cmd_r.push_length == 12'd0) ? 12'd1 : cmd_r.push_length;
              len_nxt  = cmd_r.push_length;
            end
          end
        end
      end
      S_PU_DATA: begin
        if (len_r != 12'd0) begin
          we = 1'b1; addr = wcur_r; wdata = cmd_r.push_byte;
          wcur_nxt = nx(wcur_r);
        end
        len_nxt  = 12'd1;
        prem_nxt = prem_r - 12'd1;
        if (prem_r == 12'd1) begin
          tail_nxt = (len_r != 12'd0) ? nx(wcur_r) : wcur_r;
          rsp_nxt.last = 1'b1;
        end
      end
      S_PU_DROP: begin
        rsp_nxt.status = ST_FULL;
        prem_nxt = prem_r - 12'd1;
        if (prem_r == 12'd1) begin
          drop_nxt = 1'b0;
          rsp_nxt.last = 1'b1;
        end
      end
      S_PO_RD0, S_PO_RD1, S_PO_RD2, S_PO_RD3: begin
        addr   = hp_r;
        hp_nxt = nx(hp_r);
        if (state_r != S_PO_RD0) begin
          hdr_nxt = {rdata, hdr_r[31:8]};
        end
      end
      S_PO_HWAIT: begin
        hdr_nxt = {rdata, hdr_r[31:8]};
      end
      S_PO_DECIDE: begin
        if (act_r) begin
          rsp_nxt.reported_length = hdr_r[15:0];
        end else if (head_r == tail_r) begin
          rsp_nxt.status = ST_EMPTY;
        end else if (cmd_r.read_capacity < 16'd4) begin
          rsp_nxt.status = ST_CAP_LOW;
        end else if (hdr_p4 > {17'd0, cmd_r.read_capacity}) begin
          rsp_nxt.status = ST_TOO_BIG;
          rsp_nxt.reported_length = hdr_p4[15:0];
        end else begin
          rsp_nxt.reported_length = hdr_r[15:0];
          rcur_nxt = hp_r;
          if (hdr_r == 32'd0) begin
            head_nxt = hp_r;
            rsp_nxt.last = 1'b1;
          end else begin
            orem_nxt = hdr_r[11:0];
            act_nxt  = 1'b1;
          end
        end
      end
      S_PO_BYTE: begin
        addr     = rcur_r;
        rcur_nxt = nx(rcur_r);
        if (orem_r != 12'd0) begin
          orem_nxt = orem_r - 12'd1;
        end
      end
      S_PO_BWAIT: begin
        rsp_nxt.pop_byte = rdata;
        if (orem_r == 12'd0) begin
          head_nxt = rcur_r;
          act_nxt  = 1'b0;
          rsp_nxt.last = 1'b1;
        end
      end
      S_EMIT: begin
        ov_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r <= '0; tail_r <= '0; wcur_r <= '0; rcur_r <= '0;
      prem_r <= '0; orem_r <= '0; drop_r <= 1'b0; act_r <= 1'b0;
      ov_r <= 1'b0; len_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r <= head_nxt; tail_r <= tail_nxt; wcur_r <= wcur_nxt;
      rcur_r <= rcur_nxt; prem_r <= prem_nxt; orem_r <= orem_nxt;
      drop_r <= drop_nxt; act_r <= act_nxt; ov_r <= ov_nxt; len_r <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hp_r <= hp_nxt; hk_r <= hk_nxt; hdr_r <= hdr_nxt;
    cmd_r <= cmd_nxt; rsp_r <= rsp_nxt;
  end

endmodule

// File: hw/rtl/length_prefixed_message_ring_top.sv
// ----------------------------------------------------------------------------
// length_prefixed_message_ring_top
// Byte ring of length-prefixed messages with push and pop beats.
// ----------------------------------------------------------------------------
// The input stream carries one push or pop beat per transfer. Push beats
// write one data byte; the first beat of a message also carries its length,
// and a message that does not fit is dropped with a full status. Pop beats
// return one byte of the oldest complete message and mark its last byte.
// Every input transfer yields exactly one output transfer.
// A push beat that continues a message or is dropped only writes or drops
// its byte, while the first beat of a stored message first writes the
// 4-byte header through the single ring port. Every pop beat rereads the
// header byte by byte from the same port, and a pop that returns a byte
// then reads that byte as well. The engine works on one item at a time and
// takes the next one only after its result has been accepted.
// A two-entry input queue lets the sender run ahead of the engine.
// Reset empties the ring and closes any open message; the ring contents
// themselves are not cleared. When the receiver stalls, the result is held,
// the engine waits, and once the queue is full in_tready falls.
// ----------------------------------------------------------------------------
module length_prefixed_message_ring_top #(
  parameter int unsigned BUFFER_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // operation, push_byte, push_length, read_capacity
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // status, pop_byte, reported_length
  output logic        out_tlast
);
  import lpmr_pkg::*;

  cmd_t in_cmd, q_cmd;
  rsp_t rsp;
  logic q_valid, q_ready;

  assign in_cmd.op            = in_tdata[0];
  assign in_cmd.push_byte     = in_tdata[8:1];
  assign in_cmd.push_length   = in_tdata[20:9];
  assign in_cmd.read_capacity = in_tdata[36:21];

  lpmr_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .in_cmd(in_cmd), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
  );

  lpmr_engine #(.BUFFER_BYTES(BUFFER_BYTES)) u_engine (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready),
    .q_cmd(q_cmd), .out_valid(out_tvalid), .out_ready(out_tready), .out_rsp(rsp)
  );

  assign out_tdata = {5'd0, rsp.reported_length, rsp.pop_byte, rsp.status};
  assign out_tlast = rsp.last;

endmodule

// File: tb/sv/tb_length_prefixed_message_ring_top.sv
// ----------------------------------------------------------------------------
// tb_length_prefixed_message_ring_top
// Self-checking bench of the length-prefixed message ring.
// ----------------------------------------------------------------------------
// Push and pop beats are streamed into the ring. A behavioral copy of the
// ring predicts each result transfer, which is compared field by field.
// Random gaps on both sides, plus one long receiver hold-off, exercise the
// input queue and the output stall.
// ----------------------------------------------------------------------------
module tb_length_prefixed_message_ring_top;
  import lpmr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RING_BYTES = 4096;
  localparam int unsigned WD_LIMIT = 20000;
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  pop_byte;
    logic [15:0] reported_length;
    logic        last;
  } beat_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tlast;

  length_prefixed_message_ring_top #(.BUFFER_BYTES(RING_BYTES)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  logic [7:0]  ring_mem [RING_BYTES];
  int unsigned rd_head = 0, wr_tail = 0, wr_ptr = 0, push_left = 0;
  int unsigned rd_ptr = 0, pop_left = 0;
  bit          push_drop = 0, pop_open = 0;

  logic [39:0]  beat_queue [$];
  beat_result_t expected_beats [$];
  int unsigned  error_count = 0;
  int unsigned  idle_cycles;
  bit           calm;
  bit           hold_off;

  function automatic int unsigned ring_inc(int unsigned i);
    return (i + 1 >= RING_BYTES) ? 0 : i + 1;
  endfunction

  function automatic int unsigned header_at(int unsigned p);
    int unsigned v;
    v = 0;
    for (int k = 0; k < HDR_BYTES; k++) begin
      v |= int'(ring_mem[p]) << (8 * k);
      p = ring_inc(p);
    end
    return v;
  endfunction

  function automatic beat_result_t ring_beat(logic [39:0] word);
    beat_result_t r;
    logic        op;
    logic [7:0]  b;
    int unsigned len, cap, free_bytes, after;
    op  = word[0];
    b   = word[8:1];
    len = word[20:9];
    cap = word[36:21];
    r = '0;
    if (op == OP_PUSH) begin
      if (push_left == 0) begin
        free_bytes = (rd_head > wr_tail) ? rd_head - wr_tail
                                         : rd_head + RING_BYTES - wr_tail;
        if (free_bytes <= len + HDR_BYTES) begin
          push_drop = 1;
          r.status = ST_FULL;
        end else begin
          push_drop = 0;
          wr_ptr = wr_tail;
          for (int k = 0; k < HDR_BYTES; k++) begin
            ring_mem[wr_ptr] = 8'(len >> (8 * k));
            wr_ptr = ring_inc(wr_ptr);
          end
          if (len > 0) begin
            ring_mem[wr_ptr] = b;
            wr_ptr = ring_inc(wr_ptr);
          end
        end
        push_left = (len == 0) ? 1 : len;
      end else if (push_drop) begin
        r.status = ST_FULL;
      end else begin
        ring_mem[wr_ptr] = b;
        wr_ptr = ring_inc(wr_ptr);
      end
      push_left--;
      if (push_left == 0) begin
        if (!push_drop) wr_tail = wr_ptr;
        push_drop = 0;
        r.last = 1;
      end
      return r;
    end
    if (!pop_open) begin
      if (rd_head == wr_tail) begin
        r.status = ST_EMPTY;
        return r;
      end
      if (cap < HDR_BYTES) begin
        r.status = ST_CAP_LOW;
        return r;
      end
      len = header_at(rd_head);
      after = rd_head;
      for (int k = 0; k < HDR_BYTES; k++) after = ring_inc(after);
      if (len + HDR_BYTES > cap) begin
        r.status = ST_TOO_BIG;
        r.reported_length = 16'(len + HDR_BYTES);
        return r;
      end
      r.reported_length = 16'(len);
      rd_ptr = after;
      if (len == 0) begin
        rd_head = after;
        r.last = 1;
        return r;
      end
      pop_left = len;
      pop_open = 1;
    end else begin
      r.reported_length = 16'(header_at(rd_head));
    end
    r.pop_byte = ring_mem[rd_ptr];
    rd_ptr = ring_inc(rd_ptr);
    if (pop_left > 0) pop_left--;
    if (pop_left == 0) begin
      rd_head = rd_ptr;
      pop_open = 0;
      r.last = 1;
    end
    return r;
  endfunction

  function automatic logic [39:0] pack_beat(logic op, logic [7:0] b, logic [11:0] len,
                                            logic [15:0] cap);
    return {3'b000, cap, len, b, op};
  endfunction

  task automatic add_message(int unsigned len);
    for (int unsigned i = 0; i < ((len == 0) ? 1 : len); i++)
      beat_queue.push_back(pack_beat(OP_PUSH, 8'($urandom), 12'(len), 16'($urandom)));
  endtask

  task automatic add_pops(int unsigned n, logic [15:0] cap);
    for (int unsigned i = 0; i < n; i++)
      beat_queue.push_back(pack_beat(OP_POP, 8'($urandom), 12'($urandom), cap));
  endtask

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 0;
      in_tdata  <= '0;
    end else if (!in_tvalid || in_tready) begin
      if (beat_queue.size() > 0 && (calm || hold_off || $urandom_range(99) >= 9)) begin
        in_tvalid <= 1;
        in_tdata  <= beat_queue.pop_front();
      end else begin
        in_tvalid <= 0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) expected_beats.push_back(ring_beat(in_tdata));
  end

  // Monitor
  always @(posedge clk) begin
    beat_result_t want;
    if (!rst_n) begin
      out_tready <= 0;
    end else begin
      out_tready <= !hold_off && (calm || $urandom_range(99) >= 9);
      if (out_tvalid && out_tready) begin
        if (expected_beats.size() == 0) begin
          report_mismatch("unexpected transfer", 1, 0);
        end else begin
          want = expected_beats.pop_front();
          if (out_tdata[2:0] != want.status)
            report_mismatch("status", out_tdata[2:0], want.status);
          if (out_tdata[10:3] != want.pop_byte)
            report_mismatch("pop_byte", out_tdata[10:3], want.pop_byte);
          if (out_tdata[26:11] != want.reported_length)
            report_mismatch("reported_length", out_tdata[26:11], want.reported_length);
          if (out_tdata[31:27] != 0) report_mismatch("tdata padding", out_tdata[31:27], 0);
          if (out_tlast != want.last) report_mismatch("last", out_tlast, want.last);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    int unsigned len;
    rst_n = 0;
    calm = 0;
    hold_off = 0;

    // Directed part: empty pop, low capacity, too large, zero length, and
    // a capacity that is ignored after the first beat of a popped message.
    add_pops(1, 16'hFFFF);
    add_message(0);
    add_pops(1, 16'd3);
    add_pops(1, 16'd0);
    add_pops(1, 16'd4);
    beat_queue.push_back(pack_beat(OP_PUSH, 8'hFF, 12'd2, 16'hFFFF));
    beat_queue.push_back(pack_beat(OP_PUSH, 8'h00, 12'h000, 16'h0000));
    add_pops(1, 16'd5);
    add_pops(1, 16'd6);
    add_pops(1, 16'd0);
    add_message(3);
    add_pops(1, 16'd2);
    add_pops(3, 16'hFFFF);
    add_pops(1, 16'hFFFF);
    add_message(40);
    add_pops(1, 16'd43);
    add_pops(40, 16'd44);
    add_pops(1, 16'hFFFF);

    repeat (7) @(posedge clk);
    rst_n <= 1;

    // Random part: mostly whole messages, some popped back, with noise pops.
    for (int n = 0; n < 30; n++) begin
      len = ($urandom_range(19) == 0) ? $urandom_range(60, 20) : $urandom_range(12);
      add_message(len);
      if ($urandom_range(3) != 0)
        add_pops((len == 0 ? 1 : len) + $urandom_range(1), 16'($urandom_range(1) ?
                 $urandom : $urandom_range(20)));
      if (n == 20) begin
        // An extra pop with a capacity below the header size; it is ignored if a popped message is still open.
        add_pops(1, 16'd3);
      end
    end
    add_pops(100, 16'hFFFF);

    wait (beat_queue.size() < 200);
    calm = 1;
    wait (beat_queue.size() < 150);
    calm = 0;
    hold_off = 1;
    repeat (300) @(posedge clk);
    hold_off = 0;

    wait (beat_queue.size() == 0 && !in_tvalid);
    wait (expected_beats.size() == 0);
    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/lpmr_pkg.sv
hw/rtl/lpmr_ram.sv
hw/rtl/lpmr_front.sv
hw/rtl/lpmr_engine.sv
hw/rtl/length_prefixed_message_ring_top.sv
tb/sv/tb_length_prefixed_message_ring_top.sv
